>>> hw/rtl/lct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Label contour tracer package
// Shared widths, command and register codes, controller states, the
// command/status bundles between controller and datapath, and the
// Moore-neighbour direction tables.
// ----------------------------------------------------------------------------
package lct_pkg;

  // Default sizing
  localparam int LCT_MAX_DIM    = 256;
  localparam int LCT_LABEL_BITS = 32;

  // Channel payload widths
  localparam int LCT_COMMAND_BITS   = 2;
  localparam int LCT_ADDRESS_BITS   = 16;
  localparam int LCT_VALUE_BITS     = 32;
  localparam int LCT_POINT_BITS     = 32;
  localparam int LCT_CFG_INDEX_BITS = 3;
  localparam int LCT_CFG_DATA_BITS  = 32;

  // Register field widths
  localparam int LCT_GW_BITS     = 16;
  localparam int LCT_ORIGIN_BITS = 17;
  localparam int LCT_DIM_BITS    = 9;

  // Command codes
  localparam logic [LCT_COMMAND_BITS-1:0] CMD_WRITE = 2'd0;
  localparam logic [LCT_COMMAND_BITS-1:0] CMD_START = 2'd1;
  localparam logic [LCT_COMMAND_BITS-1:0] CMD_NEXT  = 2'd2;

  // Configuration register indexes
  localparam logic [LCT_CFG_INDEX_BITS-1:0] CFG_GLOBAL_WIDTH = 3'd0;
  localparam logic [LCT_CFG_INDEX_BITS-1:0] CFG_ORIGIN_X     = 3'd1;
  localparam logic [LCT_CFG_INDEX_BITS-1:0] CFG_ORIGIN_Y     = 3'd2;
  localparam logic [LCT_CFG_INDEX_BITS-1:0] CFG_MAP_WIDTH    = 3'd3;
  localparam logic [LCT_CFG_INDEX_BITS-1:0] CFG_MAP_HEIGHT   = 3'd4;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PROBE,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } lct_state_t;

  // Controller to datapath
  typedef struct packed {
    logic write_en;
    logic scan_begin;
    logic scan_run;
    logic probe_begin;
    logic probe_run;
    logic set_none;
    logic calc_mul;
    logic calc_add;
    logic out_load;
  } lct_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic trace_active;
    logic scan_hit;
    logic scan_miss;
    logic probe_move;
    logic probe_last;
    logic probe_miss;
  } lct_stat_t;

  // Column step of each search direction
  function automatic logic signed [1:0] lct_step_dx(input logic [2:0] op);
    logic signed [1:0] d;
    case (op)
      3'd0: d = -2'sd1;
      3'd1: d = 2'sd0;
      3'd2: d = 2'sd1;
      3'd3: d = 2'sd1;
      3'd4: d = 2'sd1;
      3'd5: d = 2'sd0;
      3'd6: d = -2'sd1;
      3'd7: d = -2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

  // Row step of each search direction
  function automatic logic signed [1:0] lct_step_dy(input logic [2:0] op);
    logic signed [1:0] d;
    case (op)
      3'd0: d = 2'sd1;
      3'd1: d = 2'sd1;
      3'd2: d = 2'sd1;
      3'd3: d = 2'sd0;
      3'd4: d = -2'sd1;
      3'd5: d = -2'sd1;
      3'd6: d = -2'sd1;
      3'd7: d = 2'sd0;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

  // Search direction left behind by a move in direction op
  function automatic logic [2:0] lct_next_dir(input logic [2:0] op);
    logic [2:0] d;
    case (op)
      3'd0: d = 3'd5;
      3'd1: d = 3'd6;
      3'd2: d = 3'd7;
      3'd3: d = 3'd0;
      3'd4: d = 3'd1;
      3'd5: d = 3'd2;
      3'd6: d = 3'd3;
      3'd7: d = 3'd4;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lct_request_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command beat into the tracer.
// ----------------------------------------------------------------------------
interface lct_request_if import lct_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic [LCT_COMMAND_BITS-1:0] command;
  logic [LCT_ADDRESS_BITS-1:0] cell_address;
  logic [LCT_VALUE_BITS-1:0]   cell_value;
  logic [LCT_VALUE_BITS-1:0]   trace_label;

  modport source (output valid, command, cell_address, cell_value, trace_label,
                  input ready);
  modport sink (input valid, command, cell_address, cell_value, trace_label,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lct_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one contour point beat out of the tracer.
// ----------------------------------------------------------------------------
interface lct_result_if import lct_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [LCT_POINT_BITS-1:0] point_index;
  logic                      status;
  logic                      last_point;

  modport source (output valid, point_index, status, last_point, input ready);
  modport sink (input valid, point_index, status, last_point, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lct_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lct_cfg_if import lct_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic [LCT_CFG_INDEX_BITS-1:0] index;
  logic [LCT_CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lct_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/lct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tracer controller
// Sequences the raster scan, the neighbour probe, the index calculation and
// the hand-off to the result register.
// ----------------------------------------------------------------------------
module lct_ctrl import lct_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [LCT_COMMAND_BITS-1:0] req_command,
  output logic                        req_ready,
  input  logic                        res_ready,
  output logic                        res_valid,
  input  lct_stat_t                   stat,
  output lct_cmd_t                    cmd
);

  lct_state_t state;
  lct_state_t state_next;
  logic       res_free;

  assign res_free  = !res_valid || res_ready;
  assign req_ready = (state == ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req_command)
            CMD_START: state_next = ST_SCAN;
            CMD_NEXT:  state_next = stat.trace_active ? ST_PROBE : ST_EMIT;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat.scan_hit) begin
          state_next = ST_MUL;
        end else if (stat.scan_miss) begin
          state_next = ST_EMIT;
        end
      end
      ST_PROBE: begin
        if (stat.probe_move || stat.probe_last) begin
          state_next = ST_MUL;
        end else if (stat.probe_miss) begin
          state_next = ST_EMIT;
        end
      end
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req_command)
            CMD_WRITE: cmd.write_en = 1'b1;
            CMD_START: cmd.scan_begin = 1'b1;
            CMD_NEXT: begin
              cmd.probe_begin = stat.trace_active;
              cmd.set_none    = !stat.trace_active;
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_SCAN:  cmd.scan_run  = 1'b1;
      ST_PROBE: cmd.probe_run = 1'b1;
      ST_MUL:   cmd.calc_mul  = 1'b1;
      ST_ADD:   cmd.calc_add  = 1'b1;
      ST_EMIT:  cmd.out_load  = res_free;
      default:  cmd = '0;
    endcase
  end

  // Result valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lct_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tracer datapath
// Configuration registers, label map, scan and probe address generation,
// match checking, trace state and global index arithmetic.
// ----------------------------------------------------------------------------
module lct_datapath import lct_pkg::*; #(
  parameter int MAX_DIM    = LCT_MAX_DIM,
  parameter int LABEL_BITS = LCT_LABEL_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lct_cmd_t                      cmd,
  output lct_stat_t                     stat,
  input  logic                          cfg_write,
  input  logic [LCT_CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LCT_CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [LCT_ADDRESS_BITS-1:0]   cell_address,
  input  logic [LCT_VALUE_BITS-1:0]     cell_value,
  input  logic [LCT_VALUE_BITS-1:0]     trace_label,
  output logic [LCT_POINT_BITS-1:0]     point_index,
  output logic                          status,
  output logic                          last_point
);

  localparam int MAP_DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam int CW        = $clog2(MAX_DIM);
  localparam int DW        = $clog2(MAX_DIM + 1);
  localparam int MW        = CW + DW;

  // Configuration registers
  logic [LCT_GW_BITS-1:0]            global_width;
  logic signed [LCT_ORIGIN_BITS-1:0] origin_x;
  logic signed [LCT_ORIGIN_BITS-1:0] origin_y;
  logic [LCT_DIM_BITS-1:0]           map_width;
  logic [LCT_DIM_BITS-1:0]           map_height;

  // Trace state
  logic [CW-1:0]         cur_col;
  logic [CW-1:0]         cur_row;
  logic [AW-1:0]         start_addr;
  logic [2:0]            dir;
  logic [LABEL_BITS-1:0] active_label;
  logic                  trace_active;

  // Issue stage
  logic [CW-1:0]         scan_col;
  logic [CW-1:0]         scan_row;
  logic                  scan_done;
  logic [3:0]            probe_cnt;
  logic [LABEL_BITS-1:0] pend_label;

  // Check stage, aligned with the registered read
  logic                  chk_valid;
  logic [CW-1:0]         chk_col;
  logic [CW-1:0]         chk_row;
  logic [AW-1:0]         chk_addr;
  logic                  chk_inb;
  logic                  chk_start;
  logic [2:0]            chk_op;

  // Result path
  logic [CW-1:0]               pt_col;
  logic [CW-1:0]               pt_row;
  logic [LCT_POINT_BITS-1:0]   prod;
  logic [LCT_POINT_BITS-1:0]   res_index;
  logic                        res_status;
  logic                        res_last;

  // Combinational
  logic [DW-1:0]         eff_w;
  logic [DW-1:0]         eff_h;
  logic                  scan_col_end;
  logic                  scan_row_end;
  logic [2:0]            op;
  logic signed [CW+1:0]  nb_col;
  logic signed [CW+1:0]  nb_row;
  logic                  nb_inb;
  logic                  nb_start;
  logic [CW-1:0]         addr_col;
  logic [CW-1:0]         addr_row;
  logic [MW-1:0]         addr_mul;
  logic [AW-1:0]         rd_addr;
  logic [LABEL_BITS-1:0] rd_data;
  logic                  wr_ok;
  logic [LCT_POINT_BITS-1:0] y_sum;

  // Clamp the map size to the array
  assign eff_w = (32'(map_width) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(map_width);
  assign eff_h = (32'(map_height) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(map_height);

  // Raster scan wrap points
  assign scan_col_end = (DW'(scan_col) + DW'(1)) == eff_w;
  assign scan_row_end = (DW'(scan_row) + DW'(1)) == eff_h;

  // Neighbour under probe
  assign op     = dir + probe_cnt[2:0];
  assign nb_col = $signed({2'b00, cur_col}) + (CW+2)'(lct_step_dx(op));
  assign nb_row = $signed({2'b00, cur_row}) + (CW+2)'(lct_step_dy(op));
  assign nb_inb = !nb_col[CW+1] && !nb_row[CW+1]
                  && ((DW+1)'(nb_col[CW:0]) < (DW+1)'(eff_w))
                  && ((DW+1)'(nb_row[CW:0]) < (DW+1)'(eff_h));

  // Shared linear address: row times width plus column
  assign addr_col = cmd.probe_run ? nb_col[CW-1:0] : scan_col;
  assign addr_row = cmd.probe_run ? nb_row[CW-1:0] : scan_row;
  assign addr_mul = addr_row * eff_w;
  assign rd_addr  = AW'(addr_mul + MW'(addr_col));
  assign nb_start = nb_inb && (rd_addr == start_addr);

  // Label map
  assign wr_ok = cmd.write_en && (32'(cell_address) < 32'(MAP_DEPTH));

  lct_ram #(
    .WIDTH (LABEL_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (AW'(cell_address)),
    .wdata (LABEL_BITS'(cell_value)),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Status to the controller
  assign stat.trace_active = trace_active;
  assign stat.scan_hit     = chk_valid && (rd_data == pend_label);
  assign stat.scan_miss    = scan_done && !chk_valid;
  assign stat.probe_last   = chk_valid && chk_inb && chk_start;
  assign stat.probe_move   = chk_valid && chk_inb && !chk_start
                             && (rd_data == active_label);
  assign stat.probe_miss   = probe_cnt[3] && !chk_valid;

  // Configuration and trace control state
  always_ff @(posedge clk) begin
    if (rst) begin
      global_width <= LCT_GW_BITS'(1);
      origin_x     <= '0;
      origin_y     <= '0;
      map_width    <= LCT_DIM_BITS'(256);
      map_height   <= LCT_DIM_BITS'(256);
      cur_col      <= '0;
      cur_row      <= '0;
      start_addr   <= '0;
      dir          <= '0;
      active_label <= '0;
      trace_active <= 1'b0;
      scan_col     <= '0;
      scan_row     <= '0;
      scan_done    <= 1'b0;
      probe_cnt    <= '0;
      chk_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_GLOBAL_WIDTH: global_width <= cfg_data[LCT_GW_BITS-1:0];
          CFG_ORIGIN_X:     origin_x     <= $signed(cfg_data[LCT_ORIGIN_BITS-1:0]);
          CFG_ORIGIN_Y:     origin_y     <= $signed(cfg_data[LCT_ORIGIN_BITS-1:0]);
          CFG_MAP_WIDTH:    map_width    <= cfg_data[LCT_DIM_BITS-1:0];
          CFG_MAP_HEIGHT:   map_height   <= cfg_data[LCT_DIM_BITS-1:0];
          default: ;
        endcase
      end

      // Arm a raster scan; drop any running trace
      if (cmd.scan_begin) begin
        trace_active <= 1'b0;
        scan_col     <= '0;
        scan_row     <= '0;
        scan_done    <= (eff_w == '0) || (eff_h == '0);
        chk_valid    <= 1'b0;
      end

      if (cmd.probe_begin) begin
        probe_cnt <= '0;
        chk_valid <= 1'b0;
      end

      // Advance the scan one cell a cycle; latch the first hit
      if (cmd.scan_run) begin
        chk_valid <= !scan_done;
        if (!scan_done) begin
          if (scan_col_end) begin
            scan_col <= '0;
            if (scan_row_end) begin
              scan_done <= 1'b1;
            end else begin
              scan_row <= scan_row + CW'(1);
            end
          end else begin
            scan_col <= scan_col + CW'(1);
          end
        end
        if (stat.scan_hit) begin
          active_label <= pend_label;
          cur_col      <= chk_col;
          cur_row      <= chk_row;
          start_addr   <= chk_addr;
          dir          <= '0;
          trace_active <= 1'b1;
        end
      end

      // Probe one neighbour a cycle; move or close on the first hit
      if (cmd.probe_run) begin
        chk_valid <= !probe_cnt[3];
        if (!probe_cnt[3]) begin
          probe_cnt <= probe_cnt + 4'd1;
        end
        if (stat.probe_last || stat.probe_miss) begin
          trace_active <= 1'b0;
        end
        if (stat.probe_move) begin
          cur_col <= chk_col;
          cur_row <= chk_row;
          dir     <= lct_next_dir(chk_op);
        end
      end
    end
  end

  function automatic logic [LCT_POINT_BITS-1:0] cur_row_ext(input logic [CW-1:0] v);
    return LCT_POINT_BITS'(v);
  endfunction

  assign y_sum = LCT_POINT_BITS'(cur_row_ext(pt_row))
                 + LCT_POINT_BITS'(origin_y);

  // Payload: check stage, point and result registers
  always_ff @(posedge clk) begin
    if (cmd.scan_begin) begin
      pend_label <= LABEL_BITS'(trace_label);
    end

    if (cmd.scan_run) begin
      chk_col  <= scan_col;
      chk_row  <= scan_row;
      chk_addr <= rd_addr;
    end

    if (cmd.probe_run) begin
      chk_col   <= nb_col[CW-1:0];
      chk_row   <= nb_row[CW-1:0];
      chk_inb   <= nb_inb;
      chk_start <= nb_start;
      chk_op    <= op;
    end

    // Point to report
    if (cmd.scan_run && stat.scan_hit) begin
      pt_col     <= chk_col;
      pt_row     <= chk_row;
      res_status <= 1'b0;
      res_last   <= 1'b0;
    end
    if (cmd.probe_run && (stat.probe_move || stat.probe_last)) begin
      pt_col     <= cur_col;
      pt_row     <= cur_row;
      res_status <= 1'b0;
      res_last   <= stat.probe_last;
    end

    // No point: absent label, no trace, or stuck trace
    if (cmd.set_none || (cmd.scan_run && stat.scan_miss)
        || (cmd.probe_run && stat.probe_miss)) begin
      res_index  <= '0;
      res_status <= 1'b1;
      res_last   <= 1'b0;
    end

    // Global index, wrapping at 32 bits
    if (cmd.calc_mul) begin
      prod <= LCT_POINT_BITS'(LCT_POINT_BITS'(global_width) * y_sum);
    end
    if (cmd.calc_add) begin
      res_index <= prod + LCT_POINT_BITS'(pt_col) + LCT_POINT_BITS'(origin_x);
    end

    // Result register
    if (cmd.out_load) begin
      point_index <= res_index;
      status      <= res_status;
      last_point  <= res_last;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/label_contour_tracer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Label contour tracer unit
// Clockwise Moore-neighbour contour tracer over a loaded label map.
// ----------------------------------------------------------------------------
// One command is handled at a time; the next is taken as soon as the
// previous result sits in the output register, even if that beat has not
// yet been taken. A write beat gives no result. A start beat scans the
// map one cell a cycle through the single read port, stopping early when
// the label turns up. A next beat probes up to eight neighbours, one read
// a cycle, or none when no trace is running. The label map is not cleared
// at reset: every cell must be written before a scan or probe reaches it.
// ----------------------------------------------------------------------------
module label_contour_tracer_unit import lct_pkg::*; #(
  parameter int MAX_DIM    = LCT_MAX_DIM,
  parameter int LABEL_BITS = LCT_LABEL_BITS
) (
  input  logic        clk,
  input  logic        rst,
  lct_request_if.sink request,
  lct_result_if.source result,
  lct_cfg_if.sink     cfg
);

  lct_cmd_t  cmd;
  lct_stat_t stat;

  // Register writes are always taken
  assign cfg.ready = 1'b1;

  lct_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (request.valid),
    .req_command (request.command),
    .req_ready   (request.ready),
    .res_ready   (result.ready),
    .res_valid   (result.valid),
    .stat        (stat),
    .cmd         (cmd)
  );

  lct_datapath #(
    .MAX_DIM    (MAX_DIM),
    .LABEL_BITS (LABEL_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_write    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .cell_address (request.cell_address),
    .cell_value   (request.cell_value),
    .trace_label  (request.trace_label),
    .point_index  (result.point_index),
    .status       (result.status),
    .last_point   (result.last_point)
  );

endmodule
`default_nettype wire
